// ===== rtl/brer_pkg.sv =====
// Package for the body-rate to Euler-rate unit.
// Holds widths, Q30 angle constants, the CORDIC arctangent table and arithmetic helpers.
// Depends on nothing.
package brer_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int RATE_WIDTH      = 24;
    localparam int ANGLE_WIDTH     = 16;
    localparam int CFG_WIDTH       = 15;

    // Angle path in Q30 radians, CORDIC datapath and iteration count.
    localparam int ZW = 35;
    localparam int XW = 34;
    localparam int CN = 24;

    // Q1.15 trig values span [-32768, 32768].
    localparam int TW  = 17;
    // Product of trig and rate, and the sum of two products.
    localparam int PW  = TW + RATE_WIDTH;
    localparam int SW  = PW + 1;
    // Rounded intermediate w16.
    localparam int WW  = RATE_WIDTH + 2;
    // Dividend product, dividend magnitude, divisor magnitude.
    localparam int NPW = WW + TW;
    localparam int NW  = NPW - 1;
    localparam int DW  = TW - 1;
    // Width used for saturation.
    localparam int SATW = NW + 1;

    localparam logic signed [ZW-1:0] Q30_PI      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] Q30_HALF_PI = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] Q30_TWO_PI  = ZW'(64'sd6746518852);
    localparam logic signed [XW-1:0] CORDIC_K    = XW'(64'sd652032874);

    localparam logic signed [SATW-1:0] RATE_MAX = SATW'((64'sd1 <<< (RATE_WIDTH - 1)) - 1);
    localparam logic signed [SATW-1:0] RATE_MIN = -SATW'(64'sd1 <<< (RATE_WIDTH - 1));

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rot;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
    } t_fold;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [ZW-1:0] atan_at(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            16:      v = 32'h00003FFF;
            17:      v = 32'h00001FFF;
            18:      v = 32'h00000FFF;
            19:      v = 32'h000007FF;
            20:      v = 32'h000003FF;
            21:      v = 32'h000001FF;
            22:      v = 32'h000000FF;
            23:      v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return $signed({{(ZW-32){1'b0}}, v});
    endfunction

    // Angle to Q30, wrapped into [-pi, pi]. The raw range stays below two pi.
    function automatic logic signed [ZW-1:0] wrap_angle(input logic signed [ANGLE_WIDTH-1:0] a);
        logic signed [ZW-1:0] z;
        z = ZW'(a) <<< (30 - ANGLE_FRAC_BITS);
        if (z > Q30_PI) begin
            z = z - Q30_TWO_PI;
        end else if (z < -Q30_PI) begin
            z = z + Q30_TWO_PI;
        end
        return z;
    endfunction

    // Fold into [-pi/2, pi/2]; the flag negates sine and cosine afterward.
    function automatic t_fold fold_angle(input logic signed [ZW-1:0] z);
        t_fold f;
        f.z   = z;
        f.neg = 1'b0;
        if (z > Q30_HALF_PI) begin
            f.z   = z - Q30_PI;
            f.neg = 1'b1;
        end else if (z < -Q30_HALF_PI) begin
            f.z   = z + Q30_PI;
            f.neg = 1'b1;
        end
        return f;
    endfunction

    // One rotation-mode CORDIC iteration with floor shifts.
    function automatic t_rot rot_step(input t_rot a, input int unsigned k);
        t_rot b;
        if (a.z >= 0) begin
            b.x = a.x - (a.y >>> k);
            b.y = a.y + (a.x >>> k);
            b.z = a.z - atan_at(k);
        end else begin
            b.x = a.x + (a.y >>> k);
            b.y = a.y - (a.x >>> k);
            b.z = a.z + atan_at(k);
        end
        return b;
    endfunction

    // Q30 to Q15, nearest with ties away from zero, clamped to [-32768, 32768].
    function automatic logic signed [TW-1:0] trig_q15(input logic signed [XW-1:0] v,
                                                      input logic neg);
        logic signed [XW-1:0] a;
        logic signed [XW-1:0] t;
        a = neg ? -v : v;
        if (a >= 0) begin
            t = (a + XW'(16384)) >>> 15;
        end else begin
            t = -((-a + XW'(16384)) >>> 15);
        end
        if (t > XW'(32768)) begin
            t = XW'(32768);
        end else if (t < -XW'(32768)) begin
            t = -XW'(32768);
        end
        return t[TW-1:0];
    endfunction

    // Sum of products to Q0 rate, nearest with ties away from zero.
    function automatic logic signed [WW-1:0] round15(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        if (v >= 0) begin
            t = (v + SW'(16384)) >>> 15;
        end else begin
            t = -((-v + SW'(16384)) >>> 15);
        end
        return t[WW-1:0];
    endfunction

    // Saturate to the signed rate range.
    function automatic logic signed [RATE_WIDTH-1:0] sat_rate(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] t;
        t = v;
        if (v > RATE_MAX) begin
            t = RATE_MAX;
        end else if (v < RATE_MIN) begin
            t = RATE_MIN;
        end
        return t[RATE_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/body_rate_to_euler_rate_unit.sv =====
// Top level of the body-rate to Euler-rate unit (3-2-1 sequence).
// Pipelined CORDIC, multipliers and restoring dividers; uses brer_pkg.
//
// Usage:
//   Input channel i_valid/o_ready carries roll and pitch angles (Q2.13 rad) and
//   the body rates p, q, r (LSB 2^-16 rad/s). Output channel o_valid/i_ready
//   carries roll, pitch and yaw angle rates, saturated, plus a singular flag.
//   When |cos(pitch)| in Q1.15 is zero or below cos_threshold, singular is set
//   and all three rates are zero.
//   The threshold is written through i_cfg_wr_en/i_cfg_wr_data while idle.
// Throughput: one transaction per cycle while the skid buffer is empty. The
//   pipeline holds the 24 CORDIC iterations, one per stage, and the 42-step
//   restoring dividers, one quotient bit per stage, plus the rounding,
//   multiply and saturation stages.
// Reset: all valid bits clear, the threshold returns to 1.
// Stall: the result sits in an output register with a one-entry skid buffer.
//   While the skid buffer is empty the pipeline keeps moving and o_ready stays
//   high; once it fills, the whole pipeline holds until the receiver takes a
//   transaction. Nothing is dropped or repeated.
module body_rate_to_euler_rate_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [brer_pkg::CFG_WIDTH-1:0]         i_cfg_wr_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [brer_pkg::ANGLE_WIDTH-1:0] i_roll_angle,
    input  logic signed [brer_pkg::ANGLE_WIDTH-1:0] i_pitch_angle,
    input  logic signed [brer_pkg::RATE_WIDTH-1:0] i_body_rate_x,
    input  logic signed [brer_pkg::RATE_WIDTH-1:0] i_body_rate_y,
    input  logic signed [brer_pkg::RATE_WIDTH-1:0] i_body_rate_z,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [brer_pkg::RATE_WIDTH-1:0] o_roll_rate,
    output logic signed [brer_pkg::RATE_WIDTH-1:0] o_pitch_rate,
    output logic signed [brer_pkg::RATE_WIDTH-1:0] o_yaw_rate,
    output logic                                   o_singular
);
    import brer_pkg::*;

    localparam int RW = RATE_WIDTH;

    logic w_adv;

    // Threshold register.
    logic [CFG_WIDTH-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= CFG_WIDTH'(1);
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // Input stage.
    logic                          r_s0_v;
    logic signed [ANGLE_WIDTH-1:0] r_s0_ra, r_s0_pa;
    logic signed [RW-1:0]          r_s0_p, r_s0_q, r_s0_r;

    // Wrap stage.
    logic                 r_a1_v;
    logic signed [ZW-1:0] r_a1_rz, r_a1_pz;
    logic signed [RW-1:0] r_a1_p, r_a1_q, r_a1_r;

    // CORDIC stages; index 0 holds the folded angle and the start vector.
    logic                 r_cv   [0:CN];
    t_rot                 r_crol [0:CN];
    t_rot                 r_cpit [0:CN];
    logic                 r_crn  [0:CN];
    logic                 r_cpn  [0:CN];
    logic signed [RW-1:0] r_cp   [0:CN];
    logic signed [RW-1:0] r_cq   [0:CN];
    logic signed [RW-1:0] r_cr   [0:CN];

    // Rounded trig values and singularity test.
    logic                 r_t_v, r_t_sing;
    logic signed [TW-1:0] r_t_sr, r_t_cr, r_t_sp, r_t_cp;
    logic signed [RW-1:0] r_t_p, r_t_q, r_t_r;

    // Products.
    logic                 r_m_v, r_m_sing;
    logic signed [PW-1:0] r_m_srq, r_m_crr, r_m_crq, r_m_srr;
    logic signed [TW-1:0] r_m_sp, r_m_cp;
    logic signed [RW-1:0] r_m_p;

    // Sums and rounding.
    logic                 r_w_v, r_w_sing;
    logic signed [WW-1:0] r_w_w16;
    logic signed [RW-1:0] r_w_pr, r_w_p;
    logic signed [TW-1:0] r_w_sp, r_w_cp;

    // Dividends.
    logic                  r_n_v, r_n_sing;
    logic signed [NPW-1:0] r_n_nr, r_n_ny;
    logic signed [TW-1:0]  r_n_cp;
    logic signed [RW-1:0]  r_n_pr, r_n_p;

    // Divider stages; index 0 holds the magnitudes.
    logic                 r_dv   [0:NW];
    logic [NW-1:0]        r_dnr  [0:NW];
    logic [NW-1:0]        r_dny  [0:NW];
    logic [DW-1:0]        r_drr  [0:NW];
    logic [DW-1:0]        r_dry  [0:NW];
    logic [DW-1:0]        r_dd   [0:NW];
    logic                 r_dsr  [0:NW];
    logic                 r_dsy  [0:NW];
    logic                 r_dsg  [0:NW];
    logic signed [RW-1:0] r_dpr  [0:NW];
    logic signed [RW-1:0] r_dp   [0:NW];

    // Final stages.
    logic                   r_f1_v, r_f1_sing;
    logic signed [RW-1:0]   r_f1_yr, r_f1_pr, r_f1_p;
    logic signed [RW+1:0]   r_f1_rc;
    logic                   r_f2_v, r_f2_sing;
    logic signed [RW-1:0]   r_f2_rr, r_f2_pr, r_f2_yr;

    // Output register and skid buffer.
    logic                 r_o_v, r_o_sing, r_sk_v, r_sk_sing;
    logic signed [RW-1:0] r_o_rr, r_o_pr, r_o_yr, r_sk_rr, r_sk_pr, r_sk_yr;

    assign w_adv   = !r_sk_v;
    assign o_ready = w_adv;

    // Valid bits for the fixed stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_a1_v <= 1'b0;
            r_t_v  <= 1'b0;
            r_m_v  <= 1'b0;
            r_w_v  <= 1'b0;
            r_n_v  <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (w_adv) begin
            r_s0_v <= i_valid;
            r_a1_v <= r_s0_v;
            r_t_v  <= r_cv[CN];
            r_m_v  <= r_t_v;
            r_w_v  <= r_m_v;
            r_n_v  <= r_w_v;
            r_f1_v <= r_dv[NW];
            r_f2_v <= r_f1_v;
        end
    end

    // Capture, wrap, and rounding stages.
    always_ff @(posedge i_clk) begin
        logic signed [TW-1:0] cp;
        logic [TW-1:0]        acp;
        if (w_adv) begin
            r_s0_ra <= i_roll_angle;
            r_s0_pa <= i_pitch_angle;
            r_s0_p  <= i_body_rate_x;
            r_s0_q  <= i_body_rate_y;
            r_s0_r  <= i_body_rate_z;

            r_a1_rz <= wrap_angle(r_s0_ra);
            r_a1_pz <= wrap_angle(r_s0_pa);
            r_a1_p  <= r_s0_p;
            r_a1_q  <= r_s0_q;
            r_a1_r  <= r_s0_r;

            cp      = trig_q15(r_cpit[CN].x, r_cpn[CN]);
            acp     = cp[TW-1] ? TW'(-cp) : TW'(cp);
            r_t_sr  <= trig_q15(r_crol[CN].y, r_crn[CN]);
            r_t_cr  <= trig_q15(r_crol[CN].x, r_crn[CN]);
            r_t_sp  <= trig_q15(r_cpit[CN].y, r_cpn[CN]);
            r_t_cp  <= cp;
            r_t_sing <= (acp == '0) || (acp < TW'(r_thr));
            r_t_p   <= r_cp[CN];
            r_t_q   <= r_cq[CN];
            r_t_r   <= r_cr[CN];
        end
    end

    // Folded angle and start vector.
    always_ff @(posedge i_clk) begin
        t_fold fr, fp;
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (w_adv) begin
            r_cv[0] <= r_a1_v;
        end
        if (w_adv) begin
            fr = fold_angle(r_a1_rz);
            fp = fold_angle(r_a1_pz);
            r_crol[0] <= '{x: CORDIC_K, y: '0, z: fr.z};
            r_cpit[0] <= '{x: CORDIC_K, y: '0, z: fp.z};
            r_crn[0]  <= fr.neg;
            r_cpn[0]  <= fp.neg;
            r_cp[0]   <= r_a1_p;
            r_cq[0]   <= r_a1_q;
            r_cr[0]   <= r_a1_r;
        end
    end

    // CORDIC iterations, one per stage, for both angles side by side.
    for (genvar k = 0; k < CN; k++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_cv[k+1] <= r_cv[k];
            end
            if (w_adv) begin
                r_crol[k+1] <= rot_step(r_crol[k], k);
                r_cpit[k+1] <= rot_step(r_cpit[k], k);
                r_crn[k+1]  <= r_crn[k];
                r_cpn[k+1]  <= r_cpn[k];
                r_cp[k+1]   <= r_cp[k];
                r_cq[k+1]   <= r_cq[k];
                r_cr[k+1]   <= r_cr[k];
            end
        end
    end

    // Products, sums, dividends.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_srq  <= r_t_sr * r_t_q;
            r_m_crr  <= r_t_cr * r_t_r;
            r_m_crq  <= r_t_cr * r_t_q;
            r_m_srr  <= r_t_sr * r_t_r;
            r_m_sp   <= r_t_sp;
            r_m_cp   <= r_t_cp;
            r_m_p    <= r_t_p;
            r_m_sing <= r_t_sing;

            r_w_w16  <= round15(SW'(r_m_srq) + SW'(r_m_crr));
            r_w_pr   <= sat_rate(SATW'(round15(SW'(r_m_crq) - SW'(r_m_srr))));
            r_w_sp   <= r_m_sp;
            r_w_cp   <= r_m_cp;
            r_w_p    <= r_m_p;
            r_w_sing <= r_m_sing;

            r_n_nr   <= r_w_w16 * r_w_sp;
            r_n_ny   <= NPW'(r_w_w16) <<< 15;
            r_n_cp   <= r_w_cp;
            r_n_pr   <= r_w_pr;
            r_n_p    <= r_w_p;
            r_n_sing <= r_w_sing;
        end
    end

    // Magnitudes and quotient signs enter the dividers.
    always_ff @(posedge i_clk) begin
        logic [NPW-1:0] anr, any;
        logic [TW-1:0]  acp;
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv[0] <= r_n_v;
        end
        if (w_adv) begin
            anr = r_n_nr[NPW-1] ? NPW'(-r_n_nr) : NPW'(r_n_nr);
            any = r_n_ny[NPW-1] ? NPW'(-r_n_ny) : NPW'(r_n_ny);
            acp = r_n_cp[TW-1] ? TW'(-r_n_cp) : TW'(r_n_cp);
            r_dnr[0] <= anr[NW-1:0];
            r_dny[0] <= any[NW-1:0];
            r_drr[0] <= '0;
            r_dry[0] <= '0;
            r_dd[0]  <= acp[DW-1:0];
            r_dsr[0] <= r_n_nr[NPW-1] ^ r_n_cp[TW-1];
            r_dsy[0] <= r_n_ny[NPW-1] ^ r_n_cp[TW-1];
            r_dsg[0] <= r_n_sing;
            r_dpr[0] <= r_n_pr;
            r_dp[0]  <= r_n_p;
        end
    end

    // Restoring division, one quotient bit per stage; quotient shifts into the dividend.
    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [DW:0] w_tr, w_ty;
        logic        w_br, w_by;
        assign w_tr = {r_drr[k], r_dnr[k][NW-1]};
        assign w_ty = {r_dry[k], r_dny[k][NW-1]};
        assign w_br = w_tr >= {1'b0, r_dd[k]};
        assign w_by = w_ty >= {1'b0, r_dd[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv[k+1] <= r_dv[k];
            end
            if (w_adv) begin
                r_drr[k+1] <= w_br ? DW'(w_tr - {1'b0, r_dd[k]}) : w_tr[DW-1:0];
                r_dry[k+1] <= w_by ? DW'(w_ty - {1'b0, r_dd[k]}) : w_ty[DW-1:0];
                r_dnr[k+1] <= {r_dnr[k][NW-2:0], w_br};
                r_dny[k+1] <= {r_dny[k][NW-2:0], w_by};
                r_dd[k+1]  <= r_dd[k];
                r_dsr[k+1] <= r_dsr[k];
                r_dsy[k+1] <= r_dsy[k];
                r_dsg[k+1] <= r_dsg[k];
                r_dpr[k+1] <= r_dpr[k];
                r_dp[k+1]  <= r_dp[k];
            end
        end
    end

    // Signed quotients, clamps, then the roll sum and the singular override.
    always_ff @(posedge i_clk) begin
        logic signed [SATW-1:0] qy, qr;
        logic signed [RW+2:0]   sum;
        if (w_adv) begin
            qy = r_dsy[NW] ? -SATW'(r_dny[NW]) : SATW'(r_dny[NW]);
            qr = r_dsr[NW] ? -SATW'(r_dnr[NW]) : SATW'(r_dnr[NW]);
            if (qr > SATW'(64'sd1 <<< RW)) begin
                qr = SATW'(64'sd1 <<< RW);
            end else if (qr < -SATW'(64'sd1 <<< RW)) begin
                qr = -SATW'(64'sd1 <<< RW);
            end
            r_f1_yr   <= sat_rate(qy);
            r_f1_rc   <= qr[RW+1:0];
            r_f1_pr   <= r_dpr[NW];
            r_f1_p    <= r_dp[NW];
            r_f1_sing <= r_dsg[NW];

            sum = (RW+3)'(r_f1_p) + (RW+3)'(r_f1_rc);
            r_f2_rr   <= r_f1_sing ? '0 : sat_rate(SATW'(sum));
            r_f2_pr   <= r_f1_sing ? '0 : r_f1_pr;
            r_f2_yr   <= r_f1_sing ? '0 : r_f1_yr;
            r_f2_sing <= r_f1_sing;
        end
    end

    // Output register with a one-entry skid buffer.
    logic w_pop, w_push;
    assign w_pop  = r_o_v && i_ready;
    assign w_push = w_adv && r_f2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (w_pop) begin
                r_o_v  <= 1'b1;
                r_sk_v <= 1'b0;
            end
        end else if (!r_o_v || w_pop) begin
            r_o_v <= w_push;
        end else if (w_push) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (w_pop) begin
                r_o_rr   <= r_sk_rr;
                r_o_pr   <= r_sk_pr;
                r_o_yr   <= r_sk_yr;
                r_o_sing <= r_sk_sing;
            end
        end else if (!r_o_v || w_pop) begin
            r_o_rr   <= r_f2_rr;
            r_o_pr   <= r_f2_pr;
            r_o_yr   <= r_f2_yr;
            r_o_sing <= r_f2_sing;
        end else begin
            r_sk_rr   <= r_f2_rr;
            r_sk_pr   <= r_f2_pr;
            r_sk_yr   <= r_f2_yr;
            r_sk_sing <= r_f2_sing;
        end
    end

    assign o_valid      = r_o_v;
    assign o_roll_rate  = r_o_rr;
    assign o_pitch_rate = r_o_pr;
    assign o_yaw_rate   = r_o_yr;
    assign o_singular   = r_o_sing;

    // The skid buffer only holds a transaction behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_o_v)
        else $error("skid buffer full while output register empty");

    // A singular result carries zero rates.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_roll_rate == '0 && o_pitch_rate == '0 &&
                                     o_yaw_rate == '0))
        else $error("singular result with nonzero rates");

    // A result arriving at a stalled output register lands in the skid buffer.
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !i_ready && r_f2_v && !r_sk_v) |=> r_sk_v)
        else $error("result lost at stalled output");

    // While the skid buffer holds a transaction the pipeline is frozen.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_v && $past(r_sk_v)) |-> $stable(r_f2_rr) && $stable(r_f2_v))
        else $error("pipeline moved while stalled");

endmodule
